FILE: rtl/core/arq_pkg.sv
// shared types and constants of the adaptive range quantizer
// depends on nothing; used by the controller, the datapath and the top level
`default_nettype none

package arq_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_NBINS = 2'd1;
    localparam logic [1:0] CFG_LOW   = 2'd2;
    localparam logic [1:0] CFG_HIGH  = 2'd3;

    // range modes
    localparam logic [1:0] MODE_AUTO  = 2'd0;
    localparam logic [1:0] MODE_CLAMP = 2'd1;
    localparam logic [1:0] MODE_MAP   = 2'd2;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PREP = 9'b000000010,
        S_MUL1 = 9'b000000100,
        S_ST1  = 9'b000001000,
        S_DIV1 = 9'b000010000,
        S_MUL2 = 9'b000100000,
        S_ST2  = 9'b001000000,
        S_DIV2 = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // take the sample, update running min and max
        logic prep;       // pick range, distance and span
        logic mul1;       // numerator and denominator of the bin division
        logic mul2;       // numerator and denominator of the level division
        logic div_start;  // launch the divider
        logic bin_load;   // capture the bin quotient
        logic out_load;   // load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/core/arq_div.sv
// restoring divider, one quotient bit per cycle
// standalone; the quotient must fit in QW bits
`default_nettype none

module arq_div #(
    parameter int QW = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [2*QW+1:0]   i_num,
    input  wire logic [QW:0]       i_den,
    output logic      [QW-1:0]     o_quot,
    output logic                   o_done
);

    localparam int CW = $clog2(QW + 1);

    logic [QW:0]   r_rem;
    logic [QW-1:0] r_quo;
    logic [QW:0]   r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [QW+1:0] trial;
    logic          ge;
    logic [QW+1:0] diff;

    assign trial = {r_rem, r_quo[QW-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // upper part is below the divisor when the quotient fits
            r_rem <= i_num[2*QW:QW];
            r_quo <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[QW:0] : trial[QW:0];
            r_quo <= {r_quo[QW-2:0], ge};
        end
    end

    assign o_quot = r_quo;
    assign o_done = r_done;

endmodule

`default_nettype wire

FILE: rtl/core/arq_ctrl.sv
// sequencing state machine of the quantizer
// depends on arq_pkg; drives the datapath by t_cmd, watches t_sts
`default_nettype none

module arq_ctrl
    import arq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_ST1;
            end
            S_ST1: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV1;
            end
            S_DIV1: begin
                if (i_sts.div_done) begin
                    o_cmd.bin_load = 1'b1;
                    n_state        = S_MUL2;
                end
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_ST2;
            end
            S_ST2: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV2;
            end
            S_DIV2: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/core/arq_dp.sv
// datapath: config registers, running range, operand prep, multiplier, result register
// depends on arq_pkg and arq_div
`default_nettype none

module arq_dp
    import arq_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int BIN_BITS    = 10,
    parameter int QW          = 16,
    parameter int DATA_BITS   = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_idx,
    input  wire logic [DATA_BITS-1:0]          i_cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire t_cmd                          i_cmd,
    output t_sts                               o_sts,
    output logic [BIN_BITS-1:0]                o_bin,
    output logic signed [SAMPLE_BITS-1:0]      o_level,
    output logic                               o_zero_span
);

    localparam int S  = SAMPLE_BITS;
    localparam int B  = BIN_BITS;
    localparam int NW = 2 * QW + 2;

    // configuration
    logic [1:0]            r_mode;
    logic [B-1:0]          r_nbins;
    logic signed [S-1:0]   r_low;
    logic signed [S-1:0]   r_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_AUTO;
            r_nbins <= B'(16);
            r_low   <= {1'b1, {(S-1){1'b0}}};
            r_high  <= {1'b0, {(S-1){1'b1}}};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                CFG_NBINS: r_nbins <= i_cfg_data[B-1:0];
                CFG_LOW:   r_low   <= i_cfg_data[S-1:0];
                CFG_HIGH:  r_high  <= i_cfg_data[S-1:0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    // running range
    logic                r_first;
    logic signed [S-1:0] r_min;
    logic signed [S-1:0] r_max;
    logic signed [S-1:0] r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            r_min   <= '0;
            r_max   <= '0;
        end else if (i_cmd.load) begin
            r_first <= 1'b0;
            r_min   <= (r_first || i_sample < r_min) ? i_sample : r_min;
            r_max   <= (r_first || i_sample > r_max) ? i_sample : r_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s <= i_sample;
        end
    end

    // operand prep
    logic signed [S:0]   sx, minx, maxx, lowx, highx, v1, v, top, pt, lo_sel, hi_sel;
    logic signed [S:0]   a_full, d_full, fix_span;
    logic                zero_c;

    always_comb begin
        sx       = {r_s[S-1], r_s};
        minx     = {r_min[S-1], r_min};
        maxx     = {r_max[S-1], r_max};
        lowx     = {r_low[S-1], r_low};
        highx    = {r_high[S-1], r_high};
        fix_span = highx - lowx;
        v1       = (sx < lowx) ? lowx : sx;
        v        = (v1 > highx) ? highx : v1;
        case (r_mode)
            MODE_AUTO: begin
                hi_sel = maxx;
                lo_sel = minx;
                top    = maxx;
                pt     = sx;
                d_full = maxx - minx;
                zero_c = (d_full <= 0);
            end
            MODE_MAP: begin
                hi_sel = highx;
                lo_sel = lowx;
                top    = maxx;
                pt     = sx;
                d_full = maxx - minx;
                zero_c = (d_full <= 0) || (fix_span <= 0);
            end
            default: begin
                // clamp, also the unused fourth code
                hi_sel = highx;
                lo_sel = lowx;
                top    = highx;
                pt     = v;
                d_full = fix_span;
                zero_c = (d_full <= 0);
            end
        endcase
        a_full = top - pt;
    end

    logic signed [S-1:0] r_hi;
    logic [S-1:0]        r_a, r_d, r_span;
    logic                r_zero;
    logic signed [S:0]   span_full;

    assign span_full = hi_sel - lo_sel;

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_hi   <= hi_sel[S-1:0];
            r_a    <= a_full[S-1:0];
            r_d    <= d_full[S-1:0];
            r_span <= span_full[S-1:0];
            r_zero <= zero_c;
        end
    end

    // shared multiplier feeding the divider
    logic [B-1:0]    r_bin;
    logic [QW-1:0]   mul_x, mul_y, add_v;
    logic [2*QW-1:0] prod;
    logic [NW-1:0]   r_num;
    logic [QW:0]     r_den;

    always_comb begin
        if (i_cmd.mul2) begin
            mul_x = QW'(r_bin);
            mul_y = QW'(r_span);
            add_v = QW'(r_nbins);
        end else begin
            mul_x = QW'(r_a);
            mul_y = QW'(r_nbins);
            add_v = QW'(r_d);
        end
        prod = mul_x * mul_y;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1 || i_cmd.mul2) begin
            r_num <= {1'b0, prod, 1'b0} + NW'(add_v);
            r_den <= {add_v, 1'b0};
        end
    end

    logic [QW-1:0] quot;
    logic          div_done;

    arq_div #(
        .QW (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_quot  (quot),
        .o_done  (div_done)
    );

    assign o_sts.div_done = div_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.bin_load) begin
            r_bin <= r_zero ? '0 : quot[B-1:0];
        end
    end

    // level = hi - rounded offset
    logic signed [S:0] lvl;
    assign lvl = {r_hi[S-1], r_hi} - {1'b0, quot[S-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_bin       <= r_bin;
            o_level     <= (r_zero || r_nbins == '0) ? r_hi : lvl[S-1:0];
            o_zero_span <= r_zero;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/adaptive_range_quantizer_core.sv
// top level of the adaptive range quantizer
// depends on arq_pkg, arq_ctrl, arq_dp (which holds arq_div)
//
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+----------------------
//  input    | i_sample                            | i_in_valid / o_in_ready
//  output   | o_bin, o_level, o_zero_span         | o_out_valid / i_out_ready
//  config   | i_cfg_idx, i_cfg_data               | i_cfg_we, no wait
//
// one item at a time: a new item is taken only once the last has loaded its
// result; the two passes through the bit-serial divider (bin, then level) set
// the time from accept to a loaded result
// the result sits in an output register, so the next item is taken while it waits
// a result that finds the output register still full holds until it drains
// synchronous active-low reset clears config to defaults and the running range
`default_nettype none

module adaptive_range_quantizer_core
    import arq_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int BIN_BITS    = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [1:0]                        i_cfg_idx,
    input  wire logic [((SAMPLE_BITS > BIN_BITS) ? SAMPLE_BITS : BIN_BITS)-1:0] i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_sample,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [BIN_BITS-1:0]                    o_bin,
    output logic signed [SAMPLE_BITS-1:0]          o_level,
    output logic                                   o_zero_span
);

    // divider quotient width: bin needs BIN_BITS, level offset needs SAMPLE_BITS
    localparam int QW = (SAMPLE_BITS > BIN_BITS) ? SAMPLE_BITS : BIN_BITS;

    t_cmd cmd;
    t_sts sts;

    // sequencer: accept, prep, bin division, level division, result load
    arq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // registers, running min/max, multiplier and divider
    arq_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .BIN_BITS    (BIN_BITS),
        .QW          (QW),
        .DATA_BITS   (QW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_sample),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_bin       (o_bin),
        .o_level     (o_level),
        .o_zero_span (o_zero_span)
    );

`ifndef NO_ASSERTIONS
    // a zero span always forces bin 0
    a_zero_bin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_span |-> o_bin == '0)
        else $error("zero span with nonzero bin");

    // an accepted item makes the block busy
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after accepting an item");

    // a new result only appears from a busy sequencer
    a_result_from_work : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared while idle");
`endif

endmodule

`default_nettype wire
